>>> src/kmer_spectrum_counter_defines.svh
// Assertion macros for the k-mer spectrum counter.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef KMER_SPECTRUM_COUNTER_DEFINES_SVH
`define KMER_SPECTRUM_COUNTER_DEFINES_SVH

`ifndef SYNTH
// Check that is switched off while reset is high
`define KSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ksc check failed");
// Check that also holds across reset
`define KSC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ksc reset check failed");
`else
`define KSC_ASSERT(label, prop)
`define KSC_ASSERT_RST(label, prop)
`endif

`endif

>>> src/ksc_pkg.sv
// Shared constants, types and helper functions of the k-mer spectrum counter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ksc_pkg;

  // Table geometry
  localparam int MAX_K      = 8;
  localparam int TABLE_BITS = 2 * MAX_K;
  localparam int COUNT_BITS = 32;
  localparam int KLEN_BITS  = 4;

  localparam logic [KLEN_BITS-1:0] KLEN_RESET = KLEN_BITS'(4);

  // Register map (word index)
  localparam logic REG_KMER_LENGTH = 1'b0;

  // Input word modes
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // input word accepted
    logic clear_wr;  // zero one counter of the sweep
    logic mem_rd;    // read counter at the latched code
    logic commit;    // write back for a push and load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_mem;  // offered word needs a counter access
    logic is_clear;  // offered word starts a new sequence
    logic clr_last;  // sweep is at its last counter
    logic out_free;  // output register can take a word
  } dp_status_t;

  // k clamped to 1..MAX_K
  function automatic logic [KLEN_BITS-1:0] eff_k(input logic [KLEN_BITS-1:0] klen);
    logic [KLEN_BITS-1:0] k;
    k = klen;
    if (k < KLEN_BITS'(1)) k = KLEN_BITS'(1);
    if (k > KLEN_BITS'(MAX_K)) k = KLEN_BITS'(MAX_K);
    return k;
  endfunction

  // Mask of the low 2k bits of the window
  function automatic logic [TABLE_BITS-1:0] window_mask(input logic [KLEN_BITS-1:0] k);
    logic [TABLE_BITS-1:0] m;
    for (int i = 0; i < TABLE_BITS; i++) begin
      m[i] = (i < 2 * int'(k));
    end
    return m;
  endfunction

endpackage

>>> src/ksc_ctrl.sv
// Controller state machine of the k-mer spectrum counter.
// Depends on ksc_pkg; drives commands into ksc_datapath from its status.
`timescale 1ns / 1ps
`include "kmer_spectrum_counter_defines.svh"

module ksc_ctrl import ksc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.is_clear)      state_next = ST_CLEAR;
          else if (status.need_mem) state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold the read counter until the output register is free
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  `KSC_ASSERT_RST(a_reset_sweeps, rst |=> state == ST_CLEAR)
  `KSC_ASSERT(a_commit_free, cmd.commit |-> status.out_free)
  `KSC_ASSERT(a_read_then_update, state == ST_READ |=> state == ST_UPDATE)
  `KSC_ASSERT(a_clear_word_sweeps,
              (in_valid && in_ready && status.is_clear) |=> state == ST_CLEAR)

endmodule

>>> src/ksc_datapath.sv
// Datapath of the k-mer spectrum counter: window, counter memory, output register.
// Depends on ksc_pkg; steered by ksc_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps

module ksc_datapath import ksc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [KLEN_BITS-1:0]   kmer_length,
  input  logic [1:0]             mode,
  input  logic [1:0]             base_code,
  input  logic [TABLE_BITS-1:0]  query_code,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [TABLE_BITS-1:0]  kmer_code,
  output logic [COUNT_BITS-1:0]  kmer_count
);

  logic [TABLE_BITS-1:0] window, window_next;
  logic [KLEN_BITS-1:0]  bases_seen, bases_next;
  logic [KLEN_BITS-1:0]  k;
  logic                  counted;
  logic [TABLE_BITS-1:0] code;
  logic                  push;
  logic [TABLE_BITS-1:0] clr_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] count_new;
  logic                  mem_we;
  logic [TABLE_BITS-1:0] mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  logic [COUNT_BITS-1:0] mem [2**TABLE_BITS];

  // Rolling window step for a pushed base
  always_comb begin
    k           = eff_k(kmer_length);
    window_next = ({window[TABLE_BITS-3:0], 2'b00} | {{(TABLE_BITS-2){1'b0}}, base_code})
                  & window_mask(k);
    bases_next  = (bases_seen < KLEN_BITS'(MAX_K)) ? bases_seen + KLEN_BITS'(1) : bases_seen;
    counted     = (bases_next >= k);
  end

  // Status towards the controller
  always_comb begin
    status.need_mem = ((mode == MODE_PUSH) && counted) || (mode == MODE_QUERY);
    status.is_clear = (mode == MODE_CLEAR);
    status.clr_last = (clr_addr == {TABLE_BITS{1'b1}});
    status.out_free = !out_valid || out_ready;
  end

  // Window, base count and clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bases_seen <= '0;
      clr_addr   <= '0;
    end else begin
      if (cmd.load && (mode == MODE_PUSH)) begin
        window     <= window_next;
        bases_seen <= bases_next;
      end else if (cmd.load && (mode == MODE_CLEAR)) begin
        window     <= '0;
        bases_seen <= '0;
        clr_addr   <= '0;
      end
      if (cmd.clear_wr) clr_addr <= clr_addr + TABLE_BITS'(1);
    end
  end

  // Latched code and kind of the word in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= (mode == MODE_PUSH) ? window_next : query_code;
      push <= (mode == MODE_PUSH);
    end
  end

  // Saturating increment
  always_comb begin
    if (push) begin
      count_new = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + COUNT_BITS'(1);
    end else begin
      count_new = rd_data;
    end
    mem_we = cmd.clear_wr || (cmd.commit && push);
    mem_wa = cmd.clear_wr ? clr_addr : code;
    mem_wd = cmd.clear_wr ? '0 : count_new;
  end

  // Counter memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.mem_rd) rd_data <= mem[code];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      kmer_code  <= code;
      kmer_count <= count_new;
    end
  end

endmodule

>>> src/kmer_spectrum_counter.sv
// Top level of the k-mer spectrum counter: APB register and block wiring.
// Depends on ksc_pkg, ksc_ctrl and ksc_datapath.
//
// Use: words enter on in_valid/in_ready carrying mode, base_code and
// query_code. Mode 0 shifts a base into the rolling window; once k bases
// have been seen the counter of the window's code is incremented
// (saturating) and kmer_code/kmer_count leave on out_valid/out_ready.
// Mode 1 reads one counter and returns it the same way. Mode 2 starts a
// new sequence: window and base count clear and every counter is zeroed.
// Sequence: a word that reads a counter passes accept, memory read and
// write back; its result is loaded into the output register at write
// back. A push that gives no result, or mode 3, ends at acceptance. The
// registered read then write back of the counter memory sets this order.
// Mode 2 and reset start a sweep that zeroes the 65536 counters of the
// memory one entry per cycle; no word is accepted meanwhile, though the
// APB register can still be written. If the receiver stalls, the result
// holds in the output register; one more counter-reading word is still
// accepted and waits with its counter read until the output register frees.
// kmer_length (address 0) resets to 4 and is clamped to 1..8.
`timescale 1ns / 1ps

module kmer_spectrum_counter import ksc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [1:0]            base_code,
  input  logic [TABLE_BITS-1:0] query_code,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TABLE_BITS-1:0] kmer_code,
  output logic [COUNT_BITS-1:0] kmer_count
);

  logic [KLEN_BITS-1:0] kmer_length;
  ctrl_cmd_t            cmd;
  dp_status_t           status;

  // Register write and read back
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KMER_LENGTH)) begin
      kmer_length <= pwdata[KLEN_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KMER_LENGTH) prdata = {{(32-KLEN_BITS){1'b0}}, kmer_length};
  end

  ksc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ksc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .kmer_length (kmer_length),
    .mode        (mode),
    .base_code   (base_code),
    .query_code  (query_code),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kmer_code   (kmer_code),
    .kmer_count  (kmer_count)
  );

endmodule
